>>> design/tce_pkg.sv
package tce_pkg;

   localparam int MEM_DEPTH = 256;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int ADDR_SPAN = 256;

   typedef logic [7:0]        byte_type;
   typedef byte_type [3:0]    regs_type;
   typedef logic [MEM_AW-1:0] mem_idx_type;
   typedef mem_idx_type       idx_table_type [ADDR_SPAN];

   typedef enum logic [1:0] {
      FUNC_EXEC  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_STEP  = 2'd2,
      FUNC_SETPC = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_LOAD  = 4'd2,
      OP_STORE = 4'd3,
      OP_JLEZ  = 4'd4,
      OP_JALR  = 4'd5,
      OP_HALT  = 4'd7,
      OP_LUI   = 4'd8,
      OP_LLI   = 4'd12
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] p1;
      logic [3:0] p2;
   } decode_type;

   function automatic idx_table_type build_idx_table();
      idx_table_type t;
      for (int i = 0; i < ADDR_SPAN; i++) begin
         t[i] = MEM_AW'(i % MEM_DEPTH);
      end
      return t;
   endfunction

   localparam idx_table_type IDX_TABLE = build_idx_table();

   function automatic mem_idx_type mem_index(input logic [7:0] a);
      return IDX_TABLE[a];
   endfunction

   function automatic decode_type decode(input logic [7:0] ib);
      decode_type d;
      if (ib[7]) begin
         d.op = {ib[7:6], 2'b00};
         d.p1 = ib[5:4];
         d.p2 = ib[3:0];
      end else begin
         d.op = ib[7:4];
         d.p1 = ib[3:2];
         d.p2 = {2'b00, ib[1:0]};
      end
      return d;
   endfunction

endpackage

>>> design/tce_if.sv
interface tce_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] addr;
   logic [7:0] data;

   modport source (output valid, func, addr, data, input ready);
   modport sink (input valid, func, addr, data, output ready);
endinterface

interface tce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pc_now;
   logic [7:0] reg_a;
   logic [7:0] reg_b;
   logic [7:0] reg_c;
   logic [7:0] reg_d;
   logic [7:0] instr;
   logic       halted;
   logic       loop_seen;

   modport source (output valid, pc_now, reg_a, reg_b, reg_c, reg_d, instr, halted, loop_seen,
                   input ready);
   modport sink (input valid, pc_now, reg_a, reg_b, reg_c, reg_d, instr, halted, loop_seen,
                 output ready);
endinterface

>>> design/tiny_cpu_execute_unit.sv
// the result is registered; a step that loads passes through S_EXEC and then S_LOAD
// throughput: one transaction per cycle unless the response is stalled; a step that
// loads or stores holds off the next one (single memory port: fetch, then data access)
// reset: synchronous; clears registers, pc and per-entry valid bits, so memory reads as zero
// no clearing pass, transactions are taken from the first cycle after reset
module tiny_cpu_execute_unit (
   input logic         clock,
   input logic         reset,
   tce_req_if.sink     req_chan,
   tce_rsp_if.source   rsp_chan
);

   // architectural state
   tce_pkg::regs_type   regs_ff;
   logic [7:0]          pc_ff;

   // byte memory, one port
   logic [7:0]           main_mem_ff [tce_pkg::MEM_DEPTH];
   logic [tce_pkg::MEM_DEPTH-1:0] mem_valid_ff;
   logic [7:0]           rdata_ff;
   logic                 rd_valid_ff;
   logic                 mem_en;
   logic                 mem_we;
   tce_pkg::mem_idx_type mem_addr;
   logic [7:0]           mem_wdata;
   logic [7:0]           mem_data;

   // transaction in flight
   tce_pkg::state_type  state_ff, state_in;
   tce_pkg::func_type   s1_func_ff;
   logic [7:0]          s1_addr_ff;
   logic [7:0]          s1_data_ff;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_pc_ff;
   tce_pkg::regs_type   out_regs_ff;
   logic [7:0]          out_instr_ff;
   logic                out_halted_ff;
   logic                out_loop_ff;

   // completion
   logic                is_step;
   logic [7:0]          s1_ib;
   tce_pkg::decode_type s1_dec;
   logic                s1_halt;
   logic                step_load;
   logic                step_store;
   logic                out_free;
   logic                s1_done;
   logic [7:0]          ex_pc_base;
   tce_pkg::regs_type   ex_regs;
   logic [7:0]          ex_pc;
   tce_pkg::regs_type   cmp_regs;
   logic [7:0]          cmp_pc;
   logic [7:0]          cmp_instr;
   logic                cmp_halted;
   logic                cmp_loop;
   tce_pkg::regs_type   regs_in;
   logic [7:0]          pc_in;

   // issue
   tce_pkg::decode_type req_dec;
   logic                req_fire;

   assign mem_data = rd_valid_ff ? rdata_ff : 8'h00;

   always_comb begin
      is_step    = (s1_func_ff == tce_pkg::FUNC_STEP);
      s1_ib      = (state_ff == tce_pkg::S_EXEC && is_step) ? mem_data : s1_data_ff;
      s1_dec     = tce_pkg::decode(s1_ib);
      s1_halt    = (state_ff == tce_pkg::S_EXEC) && is_step && (s1_ib[7:4] == tce_pkg::OP_HALT);
      step_load  = (state_ff == tce_pkg::S_EXEC) && is_step && !s1_halt &&
                   (s1_dec.op == tce_pkg::OP_LOAD);
      step_store = (state_ff == tce_pkg::S_EXEC) && is_step && !s1_halt &&
                   (s1_dec.op == tce_pkg::OP_STORE);
      out_free   = !out_valid_ff || rsp_chan.ready;
      s1_done    = (((state_ff == tce_pkg::S_EXEC) && !step_load) ||
                    (state_ff == tce_pkg::S_LOAD)) && out_free;
      ex_pc_base = is_step ? (pc_ff + 8'd1) : pc_ff;
   end

   tce_exec u_exec (
      .ib        (s1_ib),
      .cur_regs  (regs_ff),
      .cur_pc    (ex_pc_base),
      .load_data (mem_data),
      .new_regs  (ex_regs),
      .new_pc    (ex_pc)
   );

   always_comb begin
      cmp_regs   = regs_ff;
      cmp_pc     = pc_ff;
      cmp_instr  = 8'h00;
      cmp_halted = 1'b0;
      cmp_loop   = 1'b0;
      unique case (s1_func_ff)
         tce_pkg::FUNC_EXEC: begin
            cmp_regs  = ex_regs;
            cmp_pc    = ex_pc;
            cmp_instr = s1_data_ff;
         end
         tce_pkg::FUNC_WRITE: ;
         tce_pkg::FUNC_STEP: begin
            cmp_instr = s1_ib;
            if (s1_halt) begin
               cmp_halted = 1'b1;
            end else begin
               cmp_regs = ex_regs;
               cmp_pc   = ex_pc;
               cmp_loop = (ex_pc == pc_ff);
            end
         end
         tce_pkg::FUNC_SETPC: cmp_pc = s1_addr_ff;
         default: ;
      endcase
      regs_in = s1_done ? cmp_regs : regs_ff;
      pc_in   = s1_done ? cmp_pc : pc_ff;
   end

   assign req_chan.ready = (state_ff == tce_pkg::S_IDLE) || (s1_done && !step_store);

   always_comb begin
      req_dec   = tce_pkg::decode(req_chan.data);
      req_fire  = req_chan.valid && req_chan.ready;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = 8'h00;
      priority if (step_load) begin
         mem_en   = 1'b1;
         mem_addr = tce_pkg::mem_index(regs_ff[s1_dec.p2[1:0]]);
      end else if (s1_done && step_store) begin
         mem_en    = 1'b1;
         mem_we    = 1'b1;
         mem_addr  = tce_pkg::mem_index(regs_ff[s1_dec.p2[1:0]]);
         mem_wdata = regs_ff[s1_dec.p1];
      end else if (req_fire) begin
         unique case (tce_pkg::func_type'(req_chan.func))
            tce_pkg::FUNC_EXEC: begin
               if (req_dec.op == tce_pkg::OP_LOAD) begin
                  mem_en   = 1'b1;
                  mem_addr = tce_pkg::mem_index(regs_in[req_dec.p2[1:0]]);
               end else if (req_dec.op == tce_pkg::OP_STORE) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = tce_pkg::mem_index(regs_in[req_dec.p2[1:0]]);
                  mem_wdata = regs_in[req_dec.p1];
               end
            end
            tce_pkg::FUNC_WRITE: begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_addr  = tce_pkg::mem_index(req_chan.addr);
               mem_wdata = req_chan.data;
            end
            tce_pkg::FUNC_STEP: begin
               mem_en   = 1'b1;
               mem_addr = tce_pkg::mem_index(pc_in);
            end
            tce_pkg::FUNC_SETPC: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tce_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = tce_pkg::S_EXEC;
            end
         end
         tce_pkg::S_EXEC: begin
            if (step_load) begin
               state_in = tce_pkg::S_LOAD;
            end else if (s1_done) begin
               state_in = req_fire ? tce_pkg::S_EXEC : tce_pkg::S_IDLE;
            end
         end
         tce_pkg::S_LOAD: begin
            if (s1_done) begin
               state_in = req_fire ? tce_pkg::S_EXEC : tce_pkg::S_IDLE;
            end
         end
         default: state_in = tce_pkg::S_IDLE;
      endcase
      out_valid_in = s1_done || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tce_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         regs_ff      <= '0;
         pc_ff        <= 8'h00;
         mem_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         regs_ff      <= regs_in;
         pc_ff        <= pc_in;
         if (mem_en && mem_we) begin
            mem_valid_ff[mem_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            main_mem_ff[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff    <= main_mem_ff[mem_addr];
            rd_valid_ff <= mem_valid_ff[mem_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff <= tce_pkg::func_type'(req_chan.func);
         s1_addr_ff <= req_chan.addr;
         s1_data_ff <= req_chan.data;
      end else if (step_load) begin
         s1_data_ff <= mem_data;
      end
      if (s1_done) begin
         out_pc_ff     <= cmp_pc;
         out_regs_ff   <= cmp_regs;
         out_instr_ff  <= cmp_instr;
         out_halted_ff <= cmp_halted;
         out_loop_ff   <= cmp_loop;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pc_now    = out_pc_ff;
   assign rsp_chan.reg_a     = out_regs_ff[0];
   assign rsp_chan.reg_b     = out_regs_ff[1];
   assign rsp_chan.reg_c     = out_regs_ff[2];
   assign rsp_chan.reg_d     = out_regs_ff[3];
   assign rsp_chan.instr     = out_instr_ff;
   assign rsp_chan.halted    = out_halted_ff;
   assign rsp_chan.loop_seen = out_loop_ff;

endmodule

>>> design/tce_exec.sv
module tce_exec (
   input  logic [7:0]        ib,
   input  tce_pkg::regs_type cur_regs,
   input  logic [7:0]        cur_pc,
   input  logic [7:0]        load_data,
   output tce_pkg::regs_type new_regs,
   output logic [7:0]        new_pc
);

   tce_pkg::decode_type dec;
   logic [7:0]          rs1;
   logic [7:0]          rs2;

   always_comb begin
      dec      = tce_pkg::decode(ib);
      rs1      = cur_regs[dec.p1];
      rs2      = cur_regs[dec.p2[1:0]];
      new_regs = cur_regs;
      new_pc   = cur_pc;
      unique case (dec.op)
         tce_pkg::OP_ADD:  new_regs[dec.p1] = rs1 + rs2;
         tce_pkg::OP_SUB:  new_regs[dec.p1] = rs1 - rs2;
         tce_pkg::OP_LOAD: new_regs[dec.p1] = load_data;
         tce_pkg::OP_JLEZ: begin
            if ((rs2 == 8'h00) || rs2[7]) begin
               new_pc = rs1;
            end
         end
         tce_pkg::OP_JALR: begin
            new_pc                  = rs1;
            new_regs[dec.p2[1:0]]   = cur_pc + 8'd1;
         end
         tce_pkg::OP_LUI:  new_regs[dec.p1] = {dec.p2, rs1[3:0]};
         tce_pkg::OP_LLI:  new_regs[dec.p1] = {rs1[7:4], dec.p2};
         default: ;
      endcase
   end

endmodule
